// ===== src/fcp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared widths, codes and helpers for the framed command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fcp_pkg;

   localparam int CHAR_W  = 8;
   localparam int CMD_W   = 3;
   localparam int PARAM_W = 44;
   localparam int ERR_W   = 3;
   localparam int COUNT_W = 5;
   localparam int CSR_IDX_W = 8;

   // longest frame accepted, in characters (3 to 31)
   localparam int MAX_LEN = 16;

   typedef logic [CHAR_W-1:0]    char_type;
   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [PARAM_W-1:0]   param_type;
   typedef logic [ERR_W-1:0]     err_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // register indexes
   localparam csr_idx_type CSR_START_CHAR = 8'd0;
   localparam csr_idx_type CSR_END_CHAR   = 8'd1;

   localparam char_type START_CHAR_RESET = 8'd35;  // '#'
   localparam char_type END_CHAR_RESET   = 8'd59;  // ';'

   // command codes
   localparam cmd_type CMD_F    = 3'd0;
   localparam cmd_type CMD_B    = 3'd1;
   localparam cmd_type CMD_L    = 3'd2;
   localparam cmd_type CMD_R    = 3'd3;
   localparam cmd_type CMD_S    = 3'd4;
   localparam cmd_type CMD_P    = 3'd5;
   localparam cmd_type CMD_NONE = 3'd7;

   // error classes
   localparam err_type ERR_NONE   = 3'd0;
   localparam err_type ERR_LENGTH = 3'd1;
   localparam err_type ERR_DELIM  = 3'd2;
   localparam err_type ERR_CMD    = 3'd3;
   localparam err_type ERR_DIGITS = 3'd4;

   localparam char_type CHAR_ZERO = 8'h30;  // '0'
   localparam char_type CHAR_NINE = 8'h39;  // '9'

   localparam count_type COUNT_MAX = 5'd31;

   function automatic cmd_type command_of(input char_type c);
      cmd_type code;
      case (c)
         8'h46:   code = CMD_F;  // 'F'
         8'h42:   code = CMD_B;  // 'B'
         8'h4C:   code = CMD_L;  // 'L'
         8'h52:   code = CMD_R;  // 'R'
         8'h53:   code = CMD_S;  // 'S'
         8'h50:   code = CMD_P;  // 'P'
         default: code = CMD_NONE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== src/fcp_if.sv =====
// ----------------------------------------------------------------------------
// fcp channel interfaces
// Valid/ready channels for characters in, parse results out and csr writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcp_req_if;
   import fcp_pkg::*;
   logic     valid;
   logic     ready;
   char_type char_value;
   logic     end_of_string;

   modport source (output valid, output char_value, output end_of_string, input ready);
   modport sink   (input valid, input char_value, input end_of_string, output ready);
endinterface

interface fcp_rsp_if;
   import fcp_pkg::*;
   logic      valid;
   logic      ready;
   logic      frame_ok;
   cmd_type   command_code;
   param_type param_value;
   err_type   error_class;

   modport source (output valid, output frame_ok, output command_code,
                   output param_value, output error_class, input ready);
   modport sink   (input valid, input frame_ok, input command_code,
                   input param_value, input error_class, output ready);
endinterface

interface fcp_csr_if;
   import fcp_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   char_type    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/framed_command_parser_top.sv =====
// ----------------------------------------------------------------------------
// framed_command_parser_top
// Parses delimited command frames, one character per beat, into a command,
// a decimal parameter and an error class.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  req_chan  in   char_value[7:0], end_of_string
//  rsp_chan  out  frame_ok, command_code[2:0], param_value[43:0], error_class[2:0]
//  csr_chan  in   index[7:0] (0 start char, 1 end char), data[7:0]
//
//  One beat per cycle while the result is not stalled; a beat is held in the input
//  register, and a frame's result is then registered in the output register.
//  The digit multiply-accumulate (x10 + digit, saturating) sets the path.
//  A waiting result stalls only the input register; one more beat is taken.
//  Synchronous reset restores both delimiters and clears the frame state.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_command_parser_top #(
   parameter int MAX_LEN = fcp_pkg::MAX_LEN
) (
   input  wire logic clock,
   input  wire logic reset,
   fcp_req_if.sink   req_chan,
   fcp_rsp_if.source rsp_chan,
   fcp_csr_if.sink   csr_chan
);
   import fcp_pkg::*;

   localparam logic [COUNT_W:0] MAX_LEN_W = (COUNT_W+1)'(MAX_LEN);
   localparam logic [COUNT_W:0] MIN_LEN_W = (COUNT_W+1)'(3);

   // input register
   logic      in_valid_ff, in_valid_in;
   char_type  in_char_ff, in_char_in;
   logic      in_last_ff, in_last_in;

   // delimiters
   char_type  start_char_ff, start_char_in;
   char_type  end_char_ff, end_char_in;

   // frame state
   count_type count_ff, count_in;
   logic      opener_ok_ff, opener_ok_in;
   char_type  cmd_byte_ff, cmd_byte_in;
   logic      digits_ok_ff, digits_ok_in;
   param_type acc_ff, acc_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_ok_ff, rsp_ok_in;
   cmd_type   rsp_cmd_ff, rsp_cmd_in;
   param_type rsp_param_ff, rsp_param_in;
   err_type   rsp_err_ff, rsp_err_in;

   logic              advance;
   logic              process;
   logic              is_digit;
   logic [PARAM_W+3:0] acc_wide;
   logic [PARAM_W+3:0] acc_mac;
   logic [COUNT_W:0]  length;
   cmd_type           cmd;
   err_type           err;
   logic [COUNT_W:0]  pos_w;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign process = in_valid_ff && advance;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_ok     = rsp_ok_ff;
   assign rsp_chan.command_code = rsp_cmd_ff;
   assign rsp_chan.param_value  = rsp_param_ff;
   assign rsp_chan.error_class  = rsp_err_ff;

   assign is_digit = (in_char_ff >= CHAR_ZERO) && (in_char_ff <= CHAR_NINE);
   assign acc_wide = {4'b0, acc_ff};
   // acc*10 + digit; saturate when it leaves 44 bits
   assign acc_mac  = (acc_wide << 3) + (acc_wide << 1)
                   + {{(PARAM_W){1'b0}}, in_char_ff[3:0]};

   assign pos_w  = {1'b0, count_ff};
   assign length = pos_w + (COUNT_W+1)'(1);
   assign cmd    = command_of(cmd_byte_ff);

   always_comb begin
      if (length < MIN_LEN_W || length > MAX_LEN_W) begin
         err = ERR_LENGTH;
      end else if (!opener_ok_ff || in_char_ff != end_char_ff) begin
         err = ERR_DELIM;
      end else if (cmd == CMD_NONE) begin
         err = ERR_CMD;
      end else if (!digits_ok_ff) begin
         err = ERR_DIGITS;
      end else begin
         err = ERR_NONE;
      end
   end

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_char_in    = in_char_ff;
      in_last_in    = in_last_ff;
      start_char_in = start_char_ff;
      end_char_in   = end_char_ff;
      count_in      = count_ff;
      opener_ok_in  = opener_ok_ff;
      cmd_byte_in   = cmd_byte_ff;
      digits_ok_in  = digits_ok_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_param_in  = rsp_param_ff;
      rsp_err_in    = rsp_err_ff;

      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_START_CHAR: start_char_in = csr_chan.data;
            CSR_END_CHAR:   end_char_in   = csr_chan.data;
            default:        ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (process) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = (err == ERR_NONE);
            rsp_cmd_in   = (err == ERR_NONE) ? cmd : CMD_F;
            rsp_param_in = (err == ERR_NONE) ? acc_ff : '0;
            rsp_err_in   = err;
            count_in     = '0;
            opener_ok_in = 1'b0;
            cmd_byte_in  = '0;
            digits_ok_in = 1'b1;
            acc_in       = '0;
         end else begin
            if (count_ff == '0) begin
               opener_ok_in = (in_char_ff == start_char_ff);
            end else if (count_ff == COUNT_W'(1)) begin
               cmd_byte_in = in_char_ff;
            end else if (pos_w < MAX_LEN_W) begin
               if (is_digit) begin
                  acc_in = (acc_mac[PARAM_W+3:PARAM_W] != 4'b0) ? '1
                                                                : acc_mac[PARAM_W-1:0];
               end else begin
                  digits_ok_in = 1'b0;
               end
            end
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
      end

      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_chan.char_value;
         in_last_in  = req_chan.end_of_string;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         start_char_ff <= START_CHAR_RESET;
         end_char_ff   <= END_CHAR_RESET;
         count_ff      <= '0;
         opener_ok_ff  <= 1'b0;
         cmd_byte_ff   <= '0;
         digits_ok_ff  <= 1'b1;
         acc_ff        <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         start_char_ff <= start_char_in;
         end_char_ff   <= end_char_in;
         count_ff      <= count_in;
         opener_ok_ff  <= opener_ok_in;
         cmd_byte_ff   <= cmd_byte_in;
         digits_ok_ff  <= digits_ok_in;
         acc_ff        <= acc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_char_ff   <= in_char_in;
      in_last_ff   <= in_last_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_param_ff <= rsp_param_in;
      rsp_err_ff   <= rsp_err_in;
   end

endmodule

`default_nettype wire
